/* sv/bbcd_pkg.sv */
// Package: types and codes of the block buffer cache directory.
`timescale 1ns / 1ps
package bbcd_pkg;

  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_DWRITE  = 3'd2;
  localparam logic [2:0] CMD_FLUSH   = 3'd3;
  localparam logic [2:0] CMD_GET     = 3'd4;

  localparam logic [2:0] KIND_GRANT  = 3'd0;
  localparam logic [2:0] KIND_WBACK  = 3'd1;
  localparam logic [2:0] KIND_FETCH  = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_VICT,
    S_FETCH,
    S_GRANT,
    S_WR,
    S_FLUSH,
    S_FDONE
  } state_t;

endpackage

/* sv/bbcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bbcd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/block_buffer_cache_directory.sv */
// Top level: block buffer cache directory with tag RAM and recency ranks.
// Get/read: the tag scan checks one slot a cycle, then the results leave.
// Write, delayed write, reject: one result. Flush: walks every slot; output stalls hold it.
// One item at a time; results leave through a single output register.
// Reset (rst, synchronous): marks clear, rank of slot i is i; tag RAM needs no clearing.
`timescale 1ns / 1ps
module block_buffer_cache_directory #(
  parameter int NUM_SLOTS  = 16,
  parameter int BLOCK_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [23:0] block_number,
  input  logic [3:0]  slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [3:0]  slot,
  output logic [23:0] block,
  output logic        hit,
  output logic        last
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  bbcd_pkg::state_t state, state_next;

  logic [2:0]            cur_cmd;
  logic [BLOCK_BITS-1:0] blk;
  logic [3:0]            si;
  logic [IW-1:0]         idx, idx_next;
  logic [IW-1:0]         raddr, raddr_next;
  logic [IW-1:0]         s, s_next;
  logic                  hit_r, hit_next;

  logic [NUM_SLOTS-1:0] valid, filled, dirty;
  logic [IW-1:0]        rank [NUM_SLOTS];

  logic [BLOCK_BITS-1:0] rdata;
  logic                  ram_we;

  logic          can_emit;
  logic          emit_en;
  logic [2:0]    e_kind;
  logic [3:0]    e_slot;
  logic [23:0]   e_block;
  logic          e_hit;
  logic          e_last;
  logic          front_en;
  logic [IW-1:0] front_slot;
  logic          mk_en;
  logic [IW-1:0] mk_slot;
  logic          mk_valid, mk_filled, mk_dirty;

  logic [NUM_SLOTS-1:0] victim_vec;
  logic [IW-1:0]        victim;
  logic [IW-1:0]        si_idx;
  logic                 si_bad;

  bbcd_ram #(.WIDTH(BLOCK_BITS), .DEPTH(NUM_SLOTS)) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s),
    .wdata(blk),
    .raddr(raddr_next),
    .rdata(rdata)
  );

  assign can_emit = !out_valid || !out_stall;
  assign in_stall = (state != bbcd_pkg::S_IDLE);
  assign si_idx   = IW'(si);
  assign si_bad   = (32'(si) >= NUM_SLOTS) || !valid[si_idx];

  always_comb begin
    victim = '0;
    for (int t = 0; t < NUM_SLOTS; t++) begin
      victim_vec[t] = (rank[t] == LAST_IDX);
      if (victim_vec[t]) begin
        victim = IW'(t);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbcd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    raddr_next = raddr;
    s_next     = s;
    hit_next   = hit_r;
    emit_en    = 1'b0;
    e_kind     = bbcd_pkg::KIND_GRANT;
    e_slot     = 4'(s);
    e_block    = 24'(blk);
    e_hit      = 1'b0;
    e_last     = 1'b0;
    front_en   = 1'b0;
    front_slot = s;
    mk_en      = 1'b0;
    mk_slot    = s;
    mk_valid   = 1'b1;
    mk_filled  = filled[s];
    mk_dirty   = dirty[s];
    ram_we     = 1'b0;
    case (state)
      bbcd_pkg::S_IDLE: begin
        if (in_valid) begin
          idx_next = '0;
          if (cmd == bbcd_pkg::CMD_READ || cmd == bbcd_pkg::CMD_GET) begin
            raddr_next = '0;
            state_next = bbcd_pkg::S_SCAN;
          end else if (cmd == bbcd_pkg::CMD_FLUSH) begin
            raddr_next = '0;
            state_next = bbcd_pkg::S_FLUSH;
          end else begin
            raddr_next = IW'(slot_index);
            state_next = bbcd_pkg::S_WR;
          end
        end
      end
      bbcd_pkg::S_SCAN: begin
        if (valid[idx] && rdata == blk) begin
          s_next     = idx;
          hit_next   = 1'b1;
          state_next = bbcd_pkg::S_FETCH;
        end else if (idx == LAST_IDX) begin
          s_next     = victim;
          raddr_next = victim;
          hit_next   = 1'b0;
          state_next = bbcd_pkg::S_VICT;
        end else begin
          idx_next   = idx + 1'b1;
          raddr_next = idx + 1'b1;
        end
      end
      bbcd_pkg::S_VICT: begin
        if (!(valid[s] && dirty[s]) || can_emit) begin
          if (valid[s] && dirty[s]) begin
            emit_en = 1'b1;
            e_kind  = bbcd_pkg::KIND_WBACK;
            e_block = 24'(rdata);
          end
          ram_we     = 1'b1;
          mk_en      = 1'b1;
          mk_filled  = 1'b0;
          mk_dirty   = 1'b0;
          front_en   = 1'b1;
          state_next = bbcd_pkg::S_FETCH;
        end
      end
      bbcd_pkg::S_FETCH: begin
        if (can_emit) begin
          emit_en = 1'b1;
          e_hit   = hit_r;
          if (cur_cmd == bbcd_pkg::CMD_READ && !filled[s]) begin
            e_kind     = bbcd_pkg::KIND_FETCH;
            mk_en      = 1'b1;
            mk_filled  = 1'b1;
            front_en   = 1'b1;
            state_next = bbcd_pkg::S_GRANT;
          end else begin
            e_last     = 1'b1;
            state_next = bbcd_pkg::S_IDLE;
          end
        end
      end
      bbcd_pkg::S_GRANT: begin
        if (can_emit) begin
          emit_en    = 1'b1;
          e_hit      = hit_r;
          e_last     = 1'b1;
          state_next = bbcd_pkg::S_IDLE;
        end
      end
      bbcd_pkg::S_WR: begin
        if (can_emit) begin
          emit_en    = 1'b1;
          e_last     = 1'b1;
          e_slot     = si;
          state_next = bbcd_pkg::S_IDLE;
          mk_slot    = si_idx;
          front_slot = si_idx;
          e_block    = 24'(rdata);
          if (cur_cmd != bbcd_pkg::CMD_WRITE && cur_cmd != bbcd_pkg::CMD_DWRITE) begin
            e_kind  = bbcd_pkg::KIND_REJECT;
            e_slot  = '0;
            e_block = '0;
          end else if (si_bad) begin
            e_kind  = bbcd_pkg::KIND_REJECT;
            e_block = '0;
          end else begin
            mk_en     = 1'b1;
            mk_filled = 1'b1;
            front_en  = 1'b1;
            if (cur_cmd == bbcd_pkg::CMD_WRITE) begin
              e_kind   = bbcd_pkg::KIND_WBACK;
              mk_dirty = 1'b0;
            end else begin
              e_kind   = bbcd_pkg::KIND_DONE;
              mk_dirty = 1'b1;
            end
          end
        end
      end
      bbcd_pkg::S_FLUSH: begin
        if (!(valid[idx] && dirty[idx]) || can_emit) begin
          if (valid[idx] && dirty[idx]) begin
            emit_en    = 1'b1;
            e_kind     = bbcd_pkg::KIND_WBACK;
            e_slot     = 4'(idx);
            e_block    = 24'(rdata);
            mk_en      = 1'b1;
            mk_slot    = idx;
            mk_filled  = 1'b1;
            mk_dirty   = 1'b0;
            front_en   = 1'b1;
            front_slot = idx;
          end
          if (idx == LAST_IDX) begin
            state_next = bbcd_pkg::S_FDONE;
          end else begin
            idx_next   = idx + 1'b1;
            raddr_next = idx + 1'b1;
          end
        end
      end
      bbcd_pkg::S_FDONE: begin
        if (can_emit) begin
          emit_en    = 1'b1;
          e_kind     = bbcd_pkg::KIND_DONE;
          e_slot     = '0;
          e_block    = '0;
          e_last     = 1'b1;
          state_next = bbcd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bbcd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    raddr <= raddr_next;
    s     <= s_next;
    hit_r <= hit_next;
    if (state == bbcd_pkg::S_IDLE && in_valid) begin
      cur_cmd <= cmd;
      blk     <= BLOCK_BITS'(block_number);
      si      <= slot_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      filled <= '0;
      dirty  <= '0;
      for (int t = 0; t < NUM_SLOTS; t++) begin
        rank[t] <= IW'(t);
      end
    end else begin
      if (mk_en) begin
        valid[mk_slot]  <= mk_valid;
        filled[mk_slot] <= mk_filled;
        dirty[mk_slot]  <= mk_dirty;
      end
      if (front_en) begin
        for (int t = 0; t < NUM_SLOTS; t++) begin
          if (IW'(t) == front_slot) begin
            rank[t] <= '0;
          end else if (rank[t] < rank[front_slot]) begin
            rank[t] <= rank[t] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      kind  <= e_kind;
      slot  <= e_slot;
      block <= e_block;
      hit   <= e_hit;
      last  <= e_last;
    end
  end

  a_victim_unique: assert property (@(posedge clk) disable iff (rst) $onehot(victim_vec))
    else $error("recency ranks are not a permutation");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    emit_en && e_last |=> state == bbcd_pkg::S_IDLE)
    else $error("final result did not return to idle");

  a_retag_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> valid[$past(s)] && rank[$past(s)] == '0)
    else $error("retagged slot not valid and most recent");

endmodule

/* verif/tb_block_buffer_cache_directory.sv */
// Testbench for the block buffer cache directory: predicted results checked item by item.
`timescale 1ns / 1ps
module tb_block_buffer_cache_directory;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [23:0] block;
    logic        hit;
    logic        last;
  } dir_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  cmd = 3'd0;
  logic [23:0] block_number = 24'd0;
  logic [3:0]  slot_index = 4'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [23:0] block;
  logic        hit;
  logic        last;

  logic [23:0] tag_m [SLOTS];
  logic        valid_m [SLOTS];
  logic        filled_m [SLOTS];
  logic        dirty_m [SLOTS];
  logic [3:0]  order_m [SLOTS];

  dir_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit gaps_on = 1'b1;
  logic [23:0] recent_blocks[$];

  block_buffer_cache_directory dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .block_number(block_number), .slot_index(slot_index), .out_valid(out_valid),
    .out_stall(out_stall), .kind(kind), .slot(slot), .block(block), .hit(hit),
    .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic model_reset();
    for (int i = 0; i < SLOTS; i++) begin
      tag_m[i] = '0;
      valid_m[i] = 1'b0;
      filled_m[i] = 1'b0;
      dirty_m[i] = 1'b0;
      order_m[i] = 4'(i);
    end
  endtask

  task automatic make_recent(input logic [3:0] s);
    int p;
    p = SLOTS - 1;
    for (int i = 0; i < SLOTS; i++)
      if (order_m[i] == s) begin
        p = i;
        break;
      end
    for (int i = p; i > 0; i--) order_m[i] = order_m[i-1];
    order_m[0] = s;
  endtask

  task automatic add_result(input logic [2:0] k, input logic [3:0] s,
                            input logic [23:0] b, input logic h);
    dir_result_t r;
    r.kind = k;
    r.slot = s;
    r.block = b;
    r.hit = h;
    r.last = 1'b0;
    pending_results.push_back(r);
  endtask

  task automatic write_back_slot(input logic [3:0] s);
    add_result(bbcd_pkg::KIND_WBACK, s, tag_m[s], 1'b0);
    dirty_m[s] = 1'b0;
    filled_m[s] = 1'b1;
    make_recent(s);
  endtask

  task automatic lookup_block(input logic [23:0] b, input bit fetch);
    logic [3:0] s;
    bit h;
    s = '0;
    h = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (valid_m[i] && tag_m[i] == b) begin
        s = 4'(i);
        h = 1'b1;
        break;
      end
    if (!h) begin
      s = order_m[SLOTS-1];
      if (valid_m[s] && dirty_m[s]) write_back_slot(s);
      tag_m[s] = b;
      valid_m[s] = 1'b1;
      filled_m[s] = 1'b0;
      dirty_m[s] = 1'b0;
      make_recent(s);
    end
    if (fetch && !filled_m[s]) begin
      add_result(bbcd_pkg::KIND_FETCH, s, b, h);
      filled_m[s] = 1'b1;
      make_recent(s);
    end
    add_result(bbcd_pkg::KIND_GRANT, s, b, h);
  endtask

  task automatic predict_directory(input logic [2:0] c, input logic [23:0] b,
                                   input logic [3:0] si);
    case (c)
      bbcd_pkg::CMD_READ: lookup_block(b, 1'b1);
      bbcd_pkg::CMD_GET: lookup_block(b, 1'b0);
      bbcd_pkg::CMD_WRITE: begin
        if (!valid_m[si]) add_result(bbcd_pkg::KIND_REJECT, si, '0, 1'b0);
        else write_back_slot(si);
      end
      bbcd_pkg::CMD_DWRITE: begin
        if (!valid_m[si]) begin
          add_result(bbcd_pkg::KIND_REJECT, si, '0, 1'b0);
        end else begin
          dirty_m[si] = 1'b1;
          filled_m[si] = 1'b1;
          make_recent(si);
          add_result(bbcd_pkg::KIND_DONE, si, tag_m[si], 1'b0);
        end
      end
      bbcd_pkg::CMD_FLUSH: begin
        for (int i = 0; i < SLOTS; i++)
          if (valid_m[i] && dirty_m[i]) write_back_slot(4'(i));
        add_result(bbcd_pkg::KIND_DONE, '0, '0, 1'b0);
      end
      default: add_result(bbcd_pkg::KIND_REJECT, '0, '0, 1'b0);
    endcase
    pending_results[$].last = 1'b1;
  endtask

  task automatic send_item(input logic [2:0] c, input logic [23:0] b, input logic [3:0] si);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    cmd <= c;
    block_number <= b;
    slot_index <= si;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_directory(c, b, si);
    items_sent++;
    if (recent_blocks.size() > 12) void'(recent_blocks.pop_front());
    recent_blocks.push_back(b);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    dir_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result kind=%0d slot=%0d block=%0h", $time, kind, slot, block);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if ({kind, slot, block, hit, last} !== exp_r) begin
          $display("%0t mismatch expected kind=%0d slot=%0d block=%0h hit=%0b last=%0b",
                   $time, exp_r.kind, exp_r.slot, exp_r.block, exp_r.hit, exp_r.last);
          $display("%0t          actual   kind=%0d slot=%0d block=%0h hit=%0b last=%0b",
                   $time, kind, slot, block, hit, last);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SLOTS + 40) @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(bbcd_pkg::CMD_WRITE, 24'h0, 4'd0);
    send_item(bbcd_pkg::CMD_DWRITE, 24'h0, 4'd15);
    send_item(bbcd_pkg::CMD_FLUSH, 24'h0, 4'd0);
    send_item(bbcd_pkg::CMD_GET, 24'h0, 4'd0);
    send_item(bbcd_pkg::CMD_READ, 24'h0, 4'd0);
    send_item(bbcd_pkg::CMD_READ, 24'hFFFFFF, 4'd0);
    send_item(bbcd_pkg::CMD_GET, 24'hFFFFFF, 4'd0);
    send_item(bbcd_pkg::CMD_DWRITE, 24'h0, 4'd0);
    send_item(bbcd_pkg::CMD_DWRITE, 24'h0, 4'd15);
    send_item(bbcd_pkg::CMD_WRITE, 24'h0, 4'd15);
    send_item(bbcd_pkg::CMD_GET, 24'hA5A5A5, 4'hF);
    send_item(bbcd_pkg::CMD_READ, 24'hA5A5A5, 4'hF);
    send_item(3'd5, 24'h123456, 4'd3);
    send_item(3'd6, 24'h0, 4'd0);
    send_item(3'd7, 24'hFFFFFF, 4'hF);
    send_item(bbcd_pkg::CMD_FLUSH, 24'h0, 4'd0);
    wait_drained();
  endtask

  task automatic test_eviction();
    for (int i = 0; i < 17; i++) begin
      send_item(bbcd_pkg::CMD_GET, 24'(32'h100 + i), 4'd0);
      if (i < 16) send_item(bbcd_pkg::CMD_DWRITE, 24'h0, 4'(15 - i));
    end
    send_item(bbcd_pkg::CMD_FLUSH, 24'h0, 4'd0);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [2:0] c;
    logic [23:0] b;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30) c = bbcd_pkg::CMD_READ;
      else if (r < 50) c = bbcd_pkg::CMD_GET;
      else if (r < 65) c = bbcd_pkg::CMD_DWRITE;
      else if (r < 78) c = bbcd_pkg::CMD_WRITE;
      else if (r < 90) c = bbcd_pkg::CMD_FLUSH;
      else c = 3'($urandom_range(0, 7));
      if (recent_blocks.size() != 0 && $urandom_range(0, 1) == 0)
        b = recent_blocks[$urandom_range(0, recent_blocks.size() - 1)];
      else if ($urandom_range(0, 1) == 0)
        b = 24'($urandom_range(0, 40));
      else
        b = 24'($urandom);
      send_item(c, b, 4'($urandom_range(0, 15)));
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    model_reset();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_eviction();
    test_random(150);
    gaps_on = 1'b0;
    test_random(30);
    wait_drained();
    $display("Covered %0d items and %0d results: misses, hits, dirty evictions,", items_sent,
             results_seen);
    $display("fetches, writes, delayed writes, flushes, rejected slots and unknown codes.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
